[sv/rfs_pkg.sv]
// Shared types, constants and helper functions for the RTP flow statistics block.
// Used by rfs_ctrl, rfs_datapath and rtp_flow_statistics_top; depends on nothing.
`default_nettype none
package rfs_pkg;

	localparam int FLOW_ENTRIES = 256;
	localparam int IDX_W = $clog2(FLOW_ENTRIES);
	localparam int CNT_W = IDX_W + 1;

	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [15:0] ETH_VLAN = 16'h8100;
	localparam logic [7:0] UDP_PROTOCOL_NUM = 8'd17;
	localparam logic [15:0] UDP_MIN_LEN = 16'd16;
	localparam logic [1:0] RTP_VERSION = 2'd2;
	localparam logic [6:0] PT_RTCP_LO = 7'd72;
	localparam logic [6:0] PT_RTCP_HI = 7'd76;
	localparam logic [6:0] PT_DTMF_LO = 7'd101;
	localparam logic [6:0] PT_DTMF_HI = 7'd102;
	localparam logic [15:0] SEQ_WINDOW = 16'd15;
	// timestamp / rate / 100, folded into one divisor
	localparam logic [31:0] DIVISOR_PLAIN = 32'd100;
	localparam logic [31:0] DIVISOR_8K = 32'd800000;
	localparam logic [31:0] DIVISOR_44K = 32'd4410000;
	// reciprocals rounded down: 2^38 / 100, 2^51 / 800000, 2^53 / 4410000
	localparam logic [31:0] RECIP_PLAIN = 32'd2748779069;
	localparam logic [31:0] RECIP_8K = 32'd2814749767;
	localparam logic [31:0] RECIP_44K = 32'd2042448810;

	typedef enum logic [2:0] {
		ST_DROPPED = 3'd0,
		ST_NEW     = 3'd1,
		ST_UPDATED = 3'd2,
		ST_NON_RTP = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CLS_RTP  = 2'd0,
		CLS_RTCP = 2'd1,
		CLS_DTMF = 2'd2,
		CLS_RSVD = 2'd3
	} class_t;

	typedef enum logic [1:0] {
		RATE_ONE = 2'd0,
		RATE_8K  = 2'd1,
		RATE_44K = 2'd2,
		RATE_UNUSED = 2'd3
	} rate_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_KEY_RD,
		S_KEY_CMP,
		S_STAT_CHK,
		S_DIV,
		S_WRITE
	} state_t;

	typedef struct packed {
		logic [31:0] ether_types;
		logic [7:0]  ip_protocol;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [31:0] port_pair;
		logic [15:0] udp_length;
		logic [1:0]  rtp_version;
		logic [6:0]  payload_type;
		logic [15:0] sequence_req;
		logic [31:0] media_stamp;
		logic [31:0] sync_source;
		logic [51:0] arrival_us;
	} in_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  flow_index;
		logic [1:0]  flow_class;
		logic [31:0] packets;
		logic [31:0] missed;
		logic [31:0] missed_size;
		logic [31:0] late;
		logic [31:0] jumps;
		logic [31:0] reordered;
		logic [63:0] min_gap_us;
		logic [63:0] max_gap_us;
		logic [31:0] jitter;
	} res_t;

	typedef struct packed {
		class_t      cls;
		rate_t       rate;
		logic [15:0] last_seq;
		logic [31:0] packets;
		logic [31:0] missed;
		logic [31:0] missed_size;
		logic [31:0] late;
		logic [31:0] jumps;
		logic [31:0] ooo;
		logic [51:0] last_arr;
		logic [63:0] min_gap;
		logic [63:0] max_gap;
		logic [31:0] jitter;
	} flow_rec_t;

	typedef struct packed {
		logic    capture;
		logic    idx_clr;
		logic    idx_inc;
		logic    key_rd;
		logic    stat_rd;
		logic    calc;
		logic    div_start;
		logic    alloc;
		logic    upd_wr;
		logic    fire;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic drop;
		logic idx_end;
		logic full;
		logic match;
		logic non_rtp;
		logic div_done;
	} dp_stat_t;

	function automatic rate_t rate_of(input logic [6:0] pt);
		rate_t r;
		unique case (pt)
			7'd0, 7'd3, 7'd4, 7'd8, 7'd9, 7'd12, 7'd18: r = RATE_8K;
			7'd10, 7'd11: r = RATE_44K;
			default: r = RATE_ONE;
		endcase
		return r;
	endfunction

	function automatic class_t class_of(input logic [6:0] pt, input logic [31:0] ports);
		class_t c;
		c = CLS_RTP;
		if (pt >= PT_RTCP_LO && pt <= PT_RTCP_HI && ports[16] && ports[0])
			c = CLS_RTCP;
		if (pt >= PT_DTMF_LO && pt <= PT_DTMF_HI)
			c = CLS_DTMF;
		return c;
	endfunction

	function automatic logic [31:0] divisor_of(input rate_t r);
		logic [31:0] d;
		unique case (r)
			RATE_8K:  d = DIVISOR_8K;
			RATE_44K: d = DIVISOR_44K;
			default:  d = DIVISOR_PLAIN;
		endcase
		return d;
	endfunction

	function automatic logic [31:0] recip_of(input rate_t r);
		logic [31:0] m;
		unique case (r)
			RATE_8K:  m = RECIP_8K;
			RATE_44K: m = RECIP_44K;
			default:  m = RECIP_PLAIN;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

[sv/rfs_ctrl.sv]
// Controller state machine: sequences check, key search, allocation and update.
// Depends on rfs_pkg; drives rfs_datapath through cmd_t and reads dp_stat_t.
`default_nettype none
module rfs_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  rfs_pkg::dp_stat_t  st,
	output rfs_pkg::cmd_t      cmd
);
	import rfs_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (start) state_d = S_CHECK;
			S_CHECK:    state_d = st.drop ? S_IDLE : S_KEY_RD;
			S_KEY_RD:   state_d = st.idx_end ? S_IDLE : S_KEY_CMP;
			S_KEY_CMP:  state_d = st.match ? S_STAT_CHK : S_KEY_RD;
			S_STAT_CHK: state_d = st.non_rtp ? S_IDLE : S_DIV;
			S_DIV:      if (st.div_done) state_d = S_WRITE;
			S_WRITE:    state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.code = ST_DROPPED;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: cmd.capture = start;
			S_CHECK: begin
				cmd.idx_clr = 1'b1;
				cmd.fire = st.drop;
			end
			S_KEY_RD: begin
				// end of used entries: allocate or report full
				if (st.idx_end) begin
					cmd.fire = 1'b1;
					cmd.alloc = !st.full;
					cmd.code = st.full ? ST_FULL : ST_NEW;
				end else begin
					cmd.key_rd = 1'b1;
				end
			end
			S_KEY_CMP: begin
				cmd.stat_rd = st.match;
				cmd.idx_inc = !st.match;
			end
			S_STAT_CHK: begin
				cmd.fire = st.non_rtp;
				cmd.code = ST_NON_RTP;
				cmd.calc = !st.non_rtp;
				cmd.div_start = !st.non_rtp;
			end
			S_DIV: ;
			S_WRITE: begin
				cmd.upd_wr = 1'b1;
				cmd.fire = 1'b1;
				cmd.code = ST_UPDATED;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[sv/rfs_datapath.sv]
// Datapath: captured header, flow key and record memories, sequence and gap
// logic, reciprocal timestamp divider and result register. Depends on rfs_pkg.
`default_nettype none
module rfs_datapath (
	input  wire               clk,
	input  wire               arst_n,
	input  rfs_pkg::in_t      item,
	input  rfs_pkg::cmd_t     cmd,
	output rfs_pkg::dp_stat_t st,
	output logic              done,
	output rfs_pkg::res_t     result
);
	import rfs_pkg::*;

	in_t              in_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] used_q;
	logic [127:0]     key_mem [FLOW_ENTRIES];
	logic [127:0]     key_rd_q;
	flow_rec_t        stat_mem [FLOW_ENTRIES];
	flow_rec_t        stat_rd_q;
	logic [127:0]     key_now;
	logic [IDX_W-1:0] addr;

	// sequence and gap evaluation
	logic [15:0] step_q;
	logic        jump_q, missed_q, late_q, ge_q;
	logic [51:0] off_q;
	logic [15:0] step;
	logic        in_order, pos_small, neg_small;

	// divider
	logic [63:0] prod_q;
	logic [31:0] quo_q;
	logic [31:0] back_q;
	logic [2:0]  div_ph_q;
	logic [31:0] divisor;
	logic [31:0] rem;

	flow_rec_t   init_rec, upd_rec, rep_rec;
	logic [35:0] jit_sum;
	logic [63:0] off_ext;
	res_t        res_d;

	assign key_now = {in_q.source_address, in_q.dest_address, in_q.port_pair, in_q.sync_source};
	assign addr = idx_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture)
			in_q <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			used_q <= '0;
		end else begin
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + 1'b1;
			if (cmd.alloc)
				used_q <= used_q + 1'b1;
		end
	end

	// key memory
	always_ff @(posedge clk) begin
		if (cmd.alloc)
			key_mem[addr] <= key_now;
		if (cmd.key_rd)
			key_rd_q <= key_mem[addr];
	end

	// record memory
	always_ff @(posedge clk) begin
		if (cmd.alloc)
			stat_mem[addr] <= init_rec;
		else if (cmd.upd_wr)
			stat_mem[addr] <= upd_rec;
		if (cmd.stat_rd)
			stat_rd_q <= stat_mem[addr];
	end

	always_comb begin
		st.drop = !(in_q.ether_types[31:16] == ETH_IPV4 ||
			(in_q.ether_types[31:16] == ETH_VLAN && in_q.ether_types[15:0] == ETH_IPV4)) ||
			in_q.ip_protocol != UDP_PROTOCOL_NUM || in_q.udp_length < UDP_MIN_LEN ||
			in_q.rtp_version != RTP_VERSION;
		st.idx_end = (idx_q == used_q);
		st.full = (used_q == CNT_W'(FLOW_ENTRIES));
		st.match = (key_rd_q == key_now);
		st.non_rtp = (stat_rd_q.cls != CLS_RTP);
		st.div_done = div_ph_q[2];
	end

	// sequence step in 16-bit two's complement
	always_comb begin
		step = in_q.sequence_req - stat_rd_q.last_seq;
		in_order = (step == 16'd1);
		pos_small = !step[15] && step <= SEQ_WINDOW && step != 16'd0;
		neg_small = step[15] && step >= (16'd0 - SEQ_WINDOW);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			step_q <= step;
			jump_q <= !in_order && !pos_small && !neg_small && step != 16'd0;
			missed_q <= !in_order && pos_small;
			late_q <= !in_order && (neg_small || step == 16'd0);
			ge_q <= (in_q.arrival_us >= stat_rd_q.last_arr);
			off_q <= in_q.arrival_us - stat_rd_q.last_arr;
		end
	end

	// reciprocal divide: product, shift, back-multiply, then one correction
	assign divisor = divisor_of(stat_rd_q.rate);
	assign rem = in_q.media_stamp - back_q;

	always_ff @(posedge clk) begin
		if (cmd.div_start)
			prod_q <= 64'(in_q.media_stamp) * 64'(recip_of(stat_rd_q.rate));
		if (div_ph_q[0]) begin
			unique case (stat_rd_q.rate)
				RATE_8K:  quo_q <= {19'd0, prod_q[63:51]};
				RATE_44K: quo_q <= {21'd0, prod_q[63:53]};
				default:  quo_q <= {6'd0, prod_q[63:38]};
			endcase
		end else if (div_ph_q[2] && rem >= divisor) begin
			// the estimate is at most one below the true quotient
			quo_q <= quo_q + 1'b1;
		end
		if (div_ph_q[1])
			back_q <= quo_q * divisor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_ph_q <= '0;
		else if (cmd.div_start)
			div_ph_q <= 3'b001;
		else
			div_ph_q <= {div_ph_q[1:0], 1'b0};
	end

	always_comb begin
		init_rec = '0;
		init_rec.cls = class_of(in_q.payload_type, in_q.port_pair);
		init_rec.rate = rate_of(in_q.payload_type);
		init_rec.last_seq = in_q.sequence_req;
		init_rec.packets = 32'd1;
		init_rec.last_arr = in_q.arrival_us;
		init_rec.min_gap = '1;
	end

	always_comb begin
		upd_rec = stat_rd_q;
		off_ext = {12'd0, off_q};
		jit_sum = {stat_rd_q.jitter, 4'd0} - {4'd0, stat_rd_q.jitter} + {4'd0, quo_q};
		if (jump_q)
			upd_rec.jumps = stat_rd_q.jumps + 1'b1;
		if (late_q)
			upd_rec.late = stat_rd_q.late + 1'b1;
		if (missed_q) begin
			upd_rec.missed = stat_rd_q.missed + 1'b1;
			upd_rec.missed_size = stat_rd_q.missed_size + {16'd0, step_q - 16'd1};
		end else if (ge_q) begin
			if (off_ext < stat_rd_q.min_gap)
				upd_rec.min_gap = off_ext;
			if (off_ext > stat_rd_q.max_gap)
				upd_rec.max_gap = off_ext;
		end else begin
			upd_rec.ooo = stat_rd_q.ooo + 1'b1;
		end
		upd_rec.jitter = jit_sum[35:4];
		upd_rec.packets = stat_rd_q.packets + 1'b1;
		upd_rec.last_seq = in_q.sequence_req;
		upd_rec.last_arr = in_q.arrival_us;
	end

	always_comb begin
		unique case (cmd.code)
			ST_NEW:     rep_rec = init_rec;
			ST_UPDATED: rep_rec = upd_rec;
			default:    rep_rec = stat_rd_q;
		endcase
		res_d = '0;
		res_d.status = cmd.code;
		if (cmd.code != ST_DROPPED && cmd.code != ST_FULL) begin
			res_d.flow_index = 8'(idx_q);
			res_d.flow_class = rep_rec.cls;
			res_d.packets = rep_rec.packets;
			res_d.missed = rep_rec.missed;
			res_d.missed_size = rep_rec.missed_size;
			res_d.late = rep_rec.late;
			res_d.jumps = rep_rec.jumps;
			res_d.reordered = rep_rec.ooo;
			res_d.min_gap_us = rep_rec.min_gap;
			res_d.max_gap_us = rep_rec.max_gap;
			res_d.jitter = rep_rec.jitter;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fire)
			result <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= cmd.fire;
	end

endmodule
`default_nettype wire

[sv/rtp_flow_statistics_top.sv]
// Top level of the RTP flow statistics block: controller plus datapath.
// Depends on rfs_pkg, rfs_ctrl and rfs_datapath.
//
// Usage: drive the packet header fields on item and raise start; the
// transaction is taken at the clock edge where start is high and busy low.
// Exactly one result per transaction appears on result for a single cycle
// with done high; the receiver cannot stall, so sample it then.
// Steps from acceptance to done, with the key search visiting at most the
// entries in use (up to FLOW_ENTRIES), one S_KEY_RD and S_KEY_CMP per entry:
//   dropped:            S_CHECK
//   new flow or full:   S_CHECK, key search ending in S_KEY_RD
//   non-RTP flow hit:   S_CHECK, key search, S_STAT_CHK
//   RTP flow update:    S_CHECK, key search, S_STAT_CHK, S_DIV, S_WRITE
// S_DIV holds the reciprocal divide. The flow search reads the single-port
// key memory one entry at a time, so a populated table takes longest. A new
// transaction may be started in the cycle done is high. Reset empties the
// table by clearing the fill count; the memories themselves are not cleared.
`default_nettype none
module rtp_flow_statistics_top (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	output logic           busy,
	input  rfs_pkg::in_t   item,
	output logic           done,
	output rfs_pkg::res_t  result
);
	import rfs_pkg::*;

	cmd_t     cmd;
	dp_stat_t st;

	rfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	rfs_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.st     (st),
		.done   (done),
		.result (result)
	);

endmodule
`default_nettype wire
